/* src/rqlb_pkg.sv */
`timescale 1ns / 1ps
package rqlb_pkg;

    localparam int QDEPTH = 2;
    localparam int NCNT   = 6;

    localparam logic [31:0] FIRST_BOUND_RST  = 32'd10000000;
    localparam logic [31:0] SECOND_BOUND_RST = 32'd20000000;
    localparam logic [31:0] THIRD_BOUND_RST  = 32'd50000000;

    // configuration register indexes
    localparam logic [1:0] CFG_FIRST  = 2'd0;
    localparam logic [1:0] CFG_SECOND = 2'd1;
    localparam logic [1:0] CFG_THIRD  = 2'd2;

    // counter slots within a group row and the global set
    localparam logic [2:0] CNT_VOL   = 3'd0;
    localparam logic [2:0] CNT_INVOL = 3'd1;
    localparam logic [2:0] CNT_BIN0  = 3'd2;

    typedef enum logic [2:0] {
        CMD_WAKEUP      = 3'd0,
        CMD_SWITCH      = 3'd1,
        CMD_EXIT        = 3'd2,
        CMD_REMOVE      = 3'd3,
        CMD_READ_GROUP  = 3'd4,
        CMD_READ_GLOBAL = 3'd5,
        CMD_NONE        = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_NO_LAT    = 2'd1,
        STS_FULL      = 2'd2,
        STS_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_PSCAN,
        S_GSCAN,
        S_ACT,
        S_BIN,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        SW_PREV_STAMP,
        SW_PREV_GROUP,
        SW_NEXT_TAKE,
        SW_NEXT_GROUP,
        SW_END
    } step_t;

    typedef enum logic [2:0] {
        ACT_STAMP,
        ACT_DEL,
        ACT_TAKE,
        ACT_BUMP,
        ACT_REMOVE,
        ACT_READ
    } act_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [63:0] now;
        logic [21:0] pid;
        logic [63:0] grp;
        logic        grp_ok;
        logic [21:0] ppid;
        logic        prun;
        logic [63:0] pgrp;
        logic        prev_stamp;
        logic        prev_count;
    } item_t;

    typedef struct packed {
        logic [31:0] first;
        logic [31:0] second;
        logic [31:0] third;
    } bounds_t;

    typedef struct packed {
        logic        vld;
        logic [21:0] tag;
        logic [63:0] stamp;
    } pend_t;

    typedef struct packed {
        logic                      vld;
        logic [63:0]               key;
        logic [NCNT-1:0][31:0]     cnt;
    } grow_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

/* src/rqlb_front.sv */
`timescale 1ns / 1ps
module rqlb_front
    import rqlb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  command,
    input  logic [63:0] now_ns,
    input  logic [21:0] task_pid,
    input  logic [63:0] task_key,
    input  logic        task_group_ok,
    input  logic [21:0] prior_pid,
    input  logic        prev_running,
    input  logic [63:0] prev_group,
    input  logic        prev_group_ok,
    input  logic        hold,
    output logic        q_valid,
    output item_t       q_item,
    input  logic        q_pop
);

    item_t      fifo_reg [QDEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    item_t      cls;
    logic       push;

    // decode the command and fold the per-task conditions into flags
    always_comb
    begin
        cls.cmd        = (command > CMD_READ_GLOBAL) ? CMD_NONE : cmd_t'(command);
        cls.now        = now_ns;
        cls.pid        = task_pid;
        cls.grp        = task_key;
        cls.grp_ok     = task_group_ok;
        cls.ppid       = prior_pid;
        cls.prun       = prev_running;
        cls.pgrp       = prev_group;
        cls.prev_stamp = prev_running && (prior_pid != '0);
        cls.prev_count = prev_group_ok && (prior_pid != '0);
    end

    assign in_ready = (cnt_reg != 2'(QDEPTH)) && !hold;
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

/* src/rqlb_back.sv */
`timescale 1ns / 1ps
module rqlb_back
    import rqlb_pkg::*;
#(
    parameter int PENDING_TASKS = 1024,
    parameter int GROUP_SLOTS   = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  bounds_t     bounds,
    input  logic        q_valid,
    input  item_t       q_item,
    output logic        q_pop,
    output logic        clearing,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [63:0] latency_ns,
    output logic [1:0]  bin,
    output logic [31:0] voluntary_count,
    output logic [31:0] involuntary_count,
    output logic [31:0] bin_one_count,
    output logic [31:0] bin_two_count,
    output logic [31:0] bin_three_count,
    output logic [31:0] bin_four_count
);

    localparam int PAW = $clog2(PENDING_TASKS);
    localparam int GAW = $clog2(GROUP_SLOTS);
    localparam logic [PAW:0]   PCOUNT = (PAW+1)'(PENDING_TASKS);
    localparam logic [GAW:0]   GCOUNT = (GAW+1)'(GROUP_SLOTS);
    localparam logic [PAW-1:0] PLAST  = PAW'(PENDING_TASKS - 1);
    localparam logic [GAW-1:0] GLAST  = GAW'(GROUP_SLOTS - 1);

    // tables
    pend_t pmem [PENDING_TASKS];
    grow_t gmem [GROUP_SLOTS];
    pend_t prd_reg;
    grow_t grd_reg;
    logic           pwe, gwe;
    logic [PAW-1:0] pwa;
    logic [GAW-1:0] gwa;
    pend_t          pwd;
    grow_t          gwd;

    state_t state_reg, state_next;
    step_t  step_reg, step_next;
    act_t   act_reg, act_next;

    logic [PAW:0]   pcnt_reg, pcnt_next;
    logic [GAW:0]   gcnt_reg, gcnt_next;
    logic           p_rd_vld_reg, p_rd_vld_next;
    logic           g_rd_vld_reg, g_rd_vld_next;
    logic [PAW-1:0] p_rd_idx_reg;
    logic [GAW-1:0] g_rd_idx_reg;

    logic           pfound_reg, pfound_next;
    logic [PAW-1:0] pidx_reg, pidx_next;
    logic           pfree_reg, pfree_next;
    logic [PAW-1:0] pfree_idx_reg, pfree_idx_next;
    logic [63:0]    ptime_reg, ptime_next;
    logic           gfound_reg, gfound_next;
    logic [GAW-1:0] gidx_reg, gidx_next;
    logic           gfree_reg, gfree_next;
    logic [GAW-1:0] gfree_idx_reg, gfree_idx_next;
    grow_t          grow_reg, grow_next;

    logic [21:0]    pkey_reg, pkey_next;
    logic [63:0]    gkey_reg, gkey_next;
    logic [2:0]     cidx_reg, cidx_next;
    status_t        sts_reg, sts_next;
    logic [63:0]    lat_reg, lat_next;
    logic [1:0]     bin_reg, bin_next;
    logic [NCNT-1:0][31:0] cnt_out_reg, cnt_out_next;
    logic [NCNT-1:0][31:0] glob_reg, glob_next;

    logic           out_vld_reg, out_vld_next;
    status_t        o_sts_reg;
    logic [63:0]    o_lat_reg;
    logic [1:0]     o_bin_reg;
    logic [NCNT-1:0][31:0] o_cnt_reg;

    item_t it;
    logic  p_last, g_last, take_miss, grp_full, out_free;
    grow_t row_tmp;

    assign it        = q_item;
    assign p_last    = p_rd_vld_reg && (p_rd_idx_reg == PLAST);
    assign g_last    = g_rd_vld_reg && (g_rd_idx_reg == GLAST);
    assign take_miss = !pfound_reg || (ptime_reg == '0);
    assign grp_full  = !gfound_reg && !gfree_reg;
    assign out_free  = !out_vld_reg || out_ready;
    assign clearing  = (state_reg == S_CLEAR);

    always_ff @(posedge clk)
    begin
        if (pwe)
        begin
            pmem[pwa] <= pwd;
        end
        prd_reg <= pmem[pcnt_reg[PAW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (gwe)
        begin
            gmem[gwa] <= gwd;
        end
        grd_reg <= gmem[gcnt_reg[GAW-1:0]];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (pcnt_reg == PCOUNT && gcnt_reg == GCOUNT)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    unique case (it.cmd)
                        CMD_WAKEUP:     state_next = (it.pid != '0) ? S_PSCAN : S_DONE;
                        CMD_SWITCH:     state_next = S_DISPATCH;
                        CMD_EXIT:       state_next = S_PSCAN;
                        CMD_REMOVE:     state_next = S_GSCAN;
                        CMD_READ_GROUP: state_next = S_GSCAN;
                        default:        state_next = S_DONE;
                    endcase
                end
            end
            S_DISPATCH:
            begin
                unique case (step_reg)
                    SW_PREV_STAMP: state_next = it.prev_stamp ? S_PSCAN : S_DISPATCH;
                    SW_PREV_GROUP: state_next = it.prev_count ? S_GSCAN : S_DISPATCH;
                    SW_NEXT_TAKE:  state_next = (it.pid != '0) ? S_PSCAN : S_DONE;
                    SW_NEXT_GROUP: state_next = it.grp_ok ? S_GSCAN : S_DONE;
                    SW_END:        state_next = S_DONE;
                    default:       state_next = S_DONE;
                endcase
            end
            S_PSCAN:
            begin
                if (p_last)
                    state_next = S_ACT;
            end
            S_GSCAN:
            begin
                if (g_last)
                    state_next = S_ACT;
            end
            S_ACT:
            begin
                unique case (act_reg)
                    ACT_STAMP: state_next = (it.cmd == CMD_SWITCH) ? S_DISPATCH : S_DONE;
                    ACT_TAKE:  state_next = take_miss ? S_DONE : S_BIN;
                    ACT_BUMP:  state_next = grp_full ? S_DONE : S_DISPATCH;
                    default:   state_next = S_DONE;
                endcase
            end
            S_BIN:
            begin
                state_next = S_DISPATCH;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and table control
    always_comb
    begin
        step_next      = step_reg;
        act_next       = act_reg;
        pcnt_next      = '0;
        gcnt_next      = '0;
        p_rd_vld_next  = 1'b0;
        g_rd_vld_next  = 1'b0;
        pfound_next    = 1'b0;
        pidx_next      = pidx_reg;
        pfree_next     = 1'b0;
        pfree_idx_next = pfree_idx_reg;
        ptime_next     = ptime_reg;
        gfound_next    = 1'b0;
        gidx_next      = gidx_reg;
        gfree_next     = 1'b0;
        gfree_idx_next = gfree_idx_reg;
        grow_next      = grow_reg;
        pkey_next      = pkey_reg;
        gkey_next      = gkey_reg;
        cidx_next      = cidx_reg;
        sts_next       = sts_reg;
        lat_next       = lat_reg;
        bin_next       = bin_reg;
        cnt_out_next   = cnt_out_reg;
        glob_next      = glob_reg;
        out_vld_next   = out_vld_reg && !out_ready;
        q_pop          = 1'b0;
        pwe            = 1'b0;
        pwa            = pidx_reg;
        pwd            = '0;
        gwe            = 1'b0;
        gwa            = gidx_reg;
        gwd            = '0;
        row_tmp        = grow_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                pcnt_next = pcnt_reg;
                gcnt_next = gcnt_reg;
                if (pcnt_reg != PCOUNT)
                begin
                    pwe       = 1'b1;
                    pwa       = pcnt_reg[PAW-1:0];
                    pcnt_next = pcnt_reg + 1'b1;
                end
                if (gcnt_reg != GCOUNT)
                begin
                    gwe       = 1'b1;
                    gwa       = gcnt_reg[GAW-1:0];
                    gcnt_next = gcnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                sts_next     = STS_OK;
                lat_next     = '0;
                bin_next     = '0;
                cnt_out_next = '0;
                step_next    = SW_PREV_STAMP;
                pkey_next    = it.pid;
                gkey_next    = it.grp;
                unique case (it.cmd)
                    CMD_WAKEUP:      act_next = ACT_STAMP;
                    CMD_EXIT:        act_next = ACT_DEL;
                    CMD_REMOVE:      act_next = ACT_REMOVE;
                    CMD_READ_GROUP:  act_next = ACT_READ;
                    CMD_READ_GLOBAL: cnt_out_next = glob_reg;
                    default:         act_next = act_reg;
                endcase
            end
            S_DISPATCH:
            begin
                unique case (step_reg)
                    SW_PREV_STAMP:
                    begin
                        step_next = SW_PREV_GROUP;
                        pkey_next = it.ppid;
                        act_next  = ACT_STAMP;
                    end
                    SW_PREV_GROUP:
                    begin
                        step_next = SW_NEXT_TAKE;
                        gkey_next = it.pgrp;
                        act_next  = ACT_BUMP;
                        cidx_next = it.prun ? CNT_INVOL : CNT_VOL;
                    end
                    SW_NEXT_TAKE:
                    begin
                        step_next = SW_NEXT_GROUP;
                        pkey_next = it.pid;
                        act_next  = ACT_TAKE;
                        if (it.pid == '0)
                            sts_next = STS_NO_LAT;
                    end
                    SW_NEXT_GROUP:
                    begin
                        step_next = SW_END;
                        gkey_next = it.grp;
                        act_next  = ACT_BUMP;
                        cidx_next = CNT_BIN0 + {1'b0, bin_reg};
                    end
                    default:
                    begin
                        step_next = SW_END;
                    end
                endcase
            end
            S_PSCAN:
            begin
                pcnt_next      = (pcnt_reg != PCOUNT) ? pcnt_reg + 1'b1 : pcnt_reg;
                p_rd_vld_next  = (pcnt_reg != PCOUNT);
                pfound_next    = pfound_reg;
                pfree_next     = pfree_reg;
                if (p_rd_vld_reg)
                begin
                    if (prd_reg.vld && prd_reg.tag == pkey_reg && !pfound_reg)
                    begin
                        pfound_next = 1'b1;
                        pidx_next   = p_rd_idx_reg;
                        ptime_next  = prd_reg.stamp;
                    end
                    if (!prd_reg.vld && !pfree_reg)
                    begin
                        pfree_next     = 1'b1;
                        pfree_idx_next = p_rd_idx_reg;
                    end
                end
            end
            S_GSCAN:
            begin
                gcnt_next      = (gcnt_reg != GCOUNT) ? gcnt_reg + 1'b1 : gcnt_reg;
                g_rd_vld_next  = (gcnt_reg != GCOUNT);
                gfound_next    = gfound_reg;
                gfree_next     = gfree_reg;
                if (g_rd_vld_reg)
                begin
                    if (grd_reg.vld && grd_reg.key == gkey_reg && !gfound_reg)
                    begin
                        gfound_next = 1'b1;
                        gidx_next   = g_rd_idx_reg;
                        grow_next   = grd_reg;
                    end
                    if (!grd_reg.vld && !gfree_reg)
                    begin
                        gfree_next     = 1'b1;
                        gfree_idx_next = g_rd_idx_reg;
                    end
                end
            end
            S_ACT:
            begin
                unique case (act_reg)
                    ACT_STAMP:
                    begin
                        // a full table drops the stamp
                        pwe = pfound_reg || pfree_reg;
                        pwa = pfound_reg ? pidx_reg : pfree_idx_reg;
                        pwd = '{vld: 1'b1, tag: pkey_reg, stamp: it.now};
                    end
                    ACT_DEL:
                    begin
                        pwe = pfound_reg;
                        pwd = '{vld: 1'b0, tag: pkey_reg, stamp: ptime_reg};
                    end
                    ACT_TAKE:
                    begin
                        if (take_miss)
                        begin
                            sts_next = STS_NO_LAT;
                        end
                        else
                        begin
                            lat_next = it.now - ptime_reg;
                            pwe      = 1'b1;
                            pwd      = '{vld: 1'b0, tag: pkey_reg, stamp: ptime_reg};
                        end
                    end
                    ACT_BUMP:
                    begin
                        if (grp_full)
                        begin
                            sts_next = STS_FULL;
                        end
                        else
                        begin
                            if (!gfound_reg)
                                row_tmp = '{vld: 1'b1, key: gkey_reg, cnt: '0};
                            row_tmp.cnt[cidx_reg] = sat_inc(row_tmp.cnt[cidx_reg]);
                            gwe = 1'b1;
                            gwa = gfound_reg ? gidx_reg : gfree_idx_reg;
                            gwd = row_tmp;
                            glob_next[cidx_reg] = sat_inc(glob_reg[cidx_reg]);
                        end
                    end
                    ACT_REMOVE:
                    begin
                        if (gfound_reg)
                        begin
                            row_tmp.vld = 1'b0;
                            gwe = 1'b1;
                            gwd = row_tmp;
                        end
                        else
                        begin
                            sts_next = STS_NOT_FOUND;
                        end
                    end
                    ACT_READ:
                    begin
                        if (gfound_reg)
                            cnt_out_next = grow_reg.cnt;
                        else
                            sts_next = STS_NOT_FOUND;
                    end
                    default:
                    begin
                        sts_next = sts_reg;
                    end
                endcase
            end
            S_BIN:
            begin
                if (lat_reg < {32'd0, bounds.first})
                    bin_next = 2'd0;
                else if (lat_reg < {32'd0, bounds.second})
                    bin_next = 2'd1;
                else if (lat_reg < {32'd0, bounds.third})
                    bin_next = 2'd2;
                else
                    bin_next = 2'd3;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_vld_next = 1'b1;
                    q_pop        = 1'b1;
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            step_reg     <= SW_PREV_STAMP;
            act_reg      <= ACT_STAMP;
            pcnt_reg     <= '0;
            gcnt_reg     <= '0;
            p_rd_vld_reg <= 1'b0;
            g_rd_vld_reg <= 1'b0;
            pfound_reg   <= 1'b0;
            pfree_reg    <= 1'b0;
            gfound_reg   <= 1'b0;
            gfree_reg    <= 1'b0;
            glob_reg     <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            act_reg      <= act_next;
            pcnt_reg     <= pcnt_next;
            gcnt_reg     <= gcnt_next;
            p_rd_vld_reg <= p_rd_vld_next;
            g_rd_vld_reg <= g_rd_vld_next;
            pfound_reg   <= pfound_next;
            pfree_reg    <= pfree_next;
            gfound_reg   <= gfound_next;
            gfree_reg    <= gfree_next;
            glob_reg     <= glob_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_rd_idx_reg  <= pcnt_reg[PAW-1:0];
        g_rd_idx_reg  <= gcnt_reg[GAW-1:0];
        pidx_reg      <= pidx_next;
        pfree_idx_reg <= pfree_idx_next;
        ptime_reg     <= ptime_next;
        gidx_reg      <= gidx_next;
        gfree_idx_reg <= gfree_idx_next;
        grow_reg      <= grow_next;
        pkey_reg      <= pkey_next;
        gkey_reg      <= gkey_next;
        cidx_reg      <= cidx_next;
        sts_reg       <= sts_next;
        lat_reg       <= lat_next;
        bin_reg       <= bin_next;
        cnt_out_reg   <= cnt_out_next;
        if (state_reg == S_DONE && out_free)
        begin
            o_sts_reg <= sts_reg;
            o_lat_reg <= lat_reg;
            o_bin_reg <= bin_reg;
            o_cnt_reg <= cnt_out_reg;
        end
    end

    assign out_valid         = out_vld_reg;
    assign status            = o_sts_reg;
    assign latency_ns        = o_lat_reg;
    assign bin               = o_bin_reg;
    assign voluntary_count   = o_cnt_reg[0];
    assign involuntary_count = o_cnt_reg[1];
    assign bin_one_count     = o_cnt_reg[2];
    assign bin_two_count     = o_cnt_reg[3];
    assign bin_three_count   = o_cnt_reg[4];
    assign bin_four_count    = o_cnt_reg[5];

endmodule

/* src/run_queue_latency_binner.sv */
`timescale 1ns / 1ps
// Run queue latency histogram for one CPU.
// Input channel (in_valid/in_ready) takes one scheduler event word: wakeup,
// switch, exit, group remove, group read or global read. Output channel
// (out_valid/out_ready) returns exactly one result word per event, in order.
// Bounds are written through cfg_we/cfg_index/cfg_data; the user must do so
// only while the block is idle, which the block itself does not enforce.
// The pending table and the group table are probed by a linear scan, one
// entry a cycle. Wakeup and exit scan the pending table, group remove and
// read scan the group table, global read scans neither; a switch runs up
// to two pending scans and two group scans. One event is worked at a time.
// A two-word queue sits in front of the engine, so events are taken while an
// earlier one is in work or its result waits on a stalled receiver; the
// engine holds a finished result while the last word waits on out_ready and
// stalls behind it. After reset both tables are swept clear with in_ready
// low; the bounds return to 10, 20 and 50 ms.
module run_queue_latency_binner
    import rqlb_pkg::*;
#(
    parameter int PENDING_TASKS = 1024,
    parameter int GROUP_SLOTS   = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  command,
    input  logic [63:0] now_ns,
    input  logic [21:0] task_pid,
    input  logic [63:0] task_key,
    input  logic        task_group_ok,
    input  logic [21:0] prior_pid,
    input  logic        prev_running,
    input  logic [63:0] prev_group,
    input  logic        prev_group_ok,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [63:0] latency_ns,
    output logic [1:0]  bin,
    output logic [31:0] voluntary_count,
    output logic [31:0] involuntary_count,
    output logic [31:0] bin_one_count,
    output logic [31:0] bin_two_count,
    output logic [31:0] bin_three_count,
    output logic [31:0] bin_four_count,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    bounds_t bounds_reg, bounds_next;
    logic    q_valid, q_pop, clearing;
    item_t   q_item;

    always_comb
    begin
        bounds_next = bounds_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FIRST:  bounds_next.first  = cfg_data;
                CFG_SECOND: bounds_next.second = cfg_data;
                CFG_THIRD:  bounds_next.third  = cfg_data;
                default:    bounds_next = bounds_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bounds_reg <= '{first: FIRST_BOUND_RST, second: SECOND_BOUND_RST,
                            third: THIRD_BOUND_RST};
        end
        else
        begin
            bounds_reg <= bounds_next;
        end
    end

    rqlb_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .now_ns        (now_ns),
        .task_pid      (task_pid),
        .task_key      (task_key),
        .task_group_ok (task_group_ok),
        .prior_pid     (prior_pid),
        .prev_running  (prev_running),
        .prev_group    (prev_group),
        .prev_group_ok (prev_group_ok),
        .hold          (clearing),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    rqlb_back #(
        .PENDING_TASKS (PENDING_TASKS),
        .GROUP_SLOTS   (GROUP_SLOTS)
    ) u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .bounds            (bounds_reg),
        .q_valid           (q_valid),
        .q_item            (q_item),
        .q_pop             (q_pop),
        .clearing          (clearing),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .status            (status),
        .latency_ns        (latency_ns),
        .bin               (bin),
        .voluntary_count   (voluntary_count),
        .involuntary_count (involuntary_count),
        .bin_one_count     (bin_one_count),
        .bin_two_count     (bin_two_count),
        .bin_three_count   (bin_three_count),
        .bin_four_count    (bin_four_count)
    );

endmodule

/* src/rqlb_checker.sv */
`timescale 1ns / 1ps
module rqlb_checker
    import rqlb_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [63:0] latency_ns,
    input logic [1:0]  bin,
    input logic [31:0] voluntary_count,
    input logic [31:0] involuntary_count,
    input logic [31:0] bin_one_count,
    input logic [31:0] bin_two_count,
    input logic [31:0] bin_three_count,
    input logic [31:0] bin_four_count
);

    logic cnt_zero;
    assign cnt_zero = (voluntary_count == '0) && (involuntary_count == '0)
                   && (bin_one_count == '0) && (bin_two_count == '0)
                   && (bin_three_count == '0) && (bin_four_count == '0);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(latency_ns) && $stable(status))
        else $error("result word changed while stalled");

    // no latency measured means nothing reported
    a_no_lat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STS_NO_LAT |-> latency_ns == '0 && bin == '0 && cnt_zero)
        else $error("missed latency carries data");

    // an absent group reads as all zero
    a_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STS_NOT_FOUND |-> latency_ns == '0 && cnt_zero)
        else $error("absent group reports data");

    // latency only comes from switches, counters only from reads
    a_lat_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && latency_ns != '0 |-> cnt_zero)
        else $error("latency and counters in one word");

endmodule

bind run_queue_latency_binner rqlb_checker u_rqlb_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .latency_ns        (latency_ns),
    .bin               (bin),
    .voluntary_count   (voluntary_count),
    .involuntary_count (involuntary_count),
    .bin_one_count     (bin_one_count),
    .bin_two_count     (bin_two_count),
    .bin_three_count   (bin_three_count),
    .bin_four_count    (bin_four_count)
);

/* test/run_queue_latency_binner_tb.sv */
`timescale 1ns / 1ps
module run_queue_latency_binner_tb;
    import rqlb_pkg::*;

    localparam int PEND_DEPTH = 1024;
    localparam int GRP_DEPTH  = 256;
    localparam int DRAIN_CYCLES = 3000;
    localparam longint CYCLE_LIMIT = 30000000;
    localparam logic [2:0] CMD_SPARE = 3'd7;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [63:0] now;
        logic [21:0] pid;
        logic [63:0] grp;
        logic        gok;
        logic [21:0] ppid;
        logic        prun;
        logic [63:0] pgrp;
        logic        pok;
    } event_t;

    typedef struct packed {
        status_t          st;
        logic [63:0]      lat;
        logic [1:0]       bin;
        logic [5:0][31:0] cnt;
    } outcome_t;

    typedef struct packed {
        event_t      ev;
        logic        typed;
        status_t     st;
        logic [63:0] lat;
        logic [1:0]  bin;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  command;
    logic [63:0] now_ns;
    logic [21:0] task_pid;
    logic [63:0] task_key;
    logic        task_group_ok;
    logic [21:0] prior_pid;
    logic        prev_running;
    logic [63:0] prev_group;
    logic        prev_group_ok;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [63:0] latency_ns;
    logic [1:0]  bin;
    logic [31:0] voluntary_count;
    logic [31:0] involuntary_count;
    logic [31:0] bin_one_count;
    logic [31:0] bin_two_count;
    logic [31:0] bin_three_count;
    logic [31:0] bin_four_count;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    run_queue_latency_binner dut (.*);

    // shadow of the block state
    logic              pend_vld  [PEND_DEPTH];
    logic [21:0]       pend_tag  [PEND_DEPTH];
    logic [63:0]       pend_time [PEND_DEPTH];
    logic              grp_vld   [GRP_DEPTH];
    logic [63:0]       grp_key   [GRP_DEPTH];
    logic [5:0][31:0]  grp_cnt   [GRP_DEPTH];
    logic [5:0][31:0]  glob_cnt;
    logic [31:0]       bound_a, bound_b, bound_c;

    outcome_t    expected_words [$];
    row_t        dir_rows [$];
    int          mismatches;
    longint      cycles = 0;
    int          sent;
    int          send_idle_pct;
    int          recv_stall_pct;
    logic [63:0] clock_ns;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic int pend_lookup(logic [21:0] pid);
        for (int i = 0; i < PEND_DEPTH; i++)
            if (pend_vld[i] && pend_tag[i] == pid)
                return i;
        return -1;
    endfunction

    function automatic void pend_mark(logic [21:0] pid, logic [63:0] t);
        int i;
        i = pend_lookup(pid);
        if (i < 0)
        begin
            for (i = 0; i < PEND_DEPTH; i++)
                if (!pend_vld[i])
                    break;
            if (i >= PEND_DEPTH)
                return;
            pend_vld[i] = 1'b1;
            pend_tag[i] = pid;
        end
        pend_time[i] = t;
    endfunction

    function automatic int group_lookup(logic [63:0] key);
        for (int i = 0; i < GRP_DEPTH; i++)
            if (grp_vld[i] && grp_key[i] == key)
                return i;
        return -1;
    endfunction

    function automatic int group_claim(logic [63:0] key);
        int i;
        i = group_lookup(key);
        if (i >= 0)
            return i;
        for (i = 0; i < GRP_DEPTH; i++)
            if (!grp_vld[i])
            begin
                grp_vld[i] = 1'b1;
                grp_key[i] = key;
                grp_cnt[i] = '0;
                return i;
            end
        return -1;
    endfunction

    function automatic void count_up(int slot, int k);
        if (grp_cnt[slot][k] != 32'hFFFF_FFFF)
            grp_cnt[slot][k] = grp_cnt[slot][k] + 1;
        if (glob_cnt[k] != 32'hFFFF_FFFF)
            glob_cnt[k] = glob_cnt[k] + 1;
    endfunction

    // histogram update for one event, returns the word the block should give
    function automatic outcome_t histogram_step(event_t e);
        outcome_t r;
        int s, p;
        logic [63:0] wait_ns;
        logic [1:0] b;
        r = '0;
        r.st = STS_OK;
        case (e.cmd)
            CMD_WAKEUP:
                if (e.pid != 0)
                    pend_mark(e.pid, e.now);
            CMD_SWITCH:
            begin
                if (e.prun && e.ppid != 0)
                    pend_mark(e.ppid, e.now);
                if (e.pok && e.ppid != 0)
                begin
                    s = group_claim(e.pgrp);
                    if (s < 0)
                    begin
                        r.st = STS_FULL;
                        return r;
                    end
                    count_up(s, e.prun ? int'(CNT_INVOL) : int'(CNT_VOL));
                end
                if (e.pid == 0)
                begin
                    r.st = STS_NO_LAT;
                    return r;
                end
                p = pend_lookup(e.pid);
                if (p < 0 || pend_time[p] == 0)
                begin
                    r.st = STS_NO_LAT;
                    return r;
                end
                wait_ns = e.now - pend_time[p];
                pend_vld[p] = 1'b0;
                if (wait_ns < {32'd0, bound_a})
                    b = 2'd0;
                else if (wait_ns < {32'd0, bound_b})
                    b = 2'd1;
                else if (wait_ns < {32'd0, bound_c})
                    b = 2'd2;
                else
                    b = 2'd3;
                r.lat = wait_ns;
                r.bin = b;
                if (e.gok)
                begin
                    s = group_claim(e.grp);
                    if (s < 0)
                    begin
                        r.st = STS_FULL;
                        return r;
                    end
                    count_up(s, int'(CNT_BIN0) + int'(b));
                end
            end
            CMD_EXIT:
            begin
                p = pend_lookup(e.pid);
                if (p >= 0)
                    pend_vld[p] = 1'b0;
            end
            CMD_REMOVE:
            begin
                s = group_lookup(e.grp);
                if (s < 0)
                    r.st = STS_NOT_FOUND;
                else
                    grp_vld[s] = 1'b0;
            end
            CMD_READ_GROUP:
            begin
                s = group_lookup(e.grp);
                if (s < 0)
                    r.st = STS_NOT_FOUND;
                else
                    r.cnt = grp_cnt[s];
            end
            CMD_READ_GLOBAL:
                r.cnt = glob_cnt;
            default:
                ;
        endcase
        return r;
    endfunction

    function automatic event_t mk(logic [2:0] cmd, logic [63:0] now, logic [21:0] pid,
                                  logic [63:0] grp, logic gok, logic [21:0] ppid,
                                  logic prun, logic [63:0] pgrp, logic pok);
        event_t e;
        e = '{cmd, now, pid, grp, gok, ppid, prun, pgrp, pok};
        return e;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
        mismatches++;
    endtask

    always @(negedge clk)
        out_ready = (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        outcome_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
                report_mismatch("word with nothing expected", {62'd0, status}, 64'd0);
            else
            begin
                w = expected_words.pop_front();
                if (status != w.st)
                    report_mismatch("status", 64'(status), 64'(w.st));
                if (latency_ns != w.lat)
                    report_mismatch("latency_ns", latency_ns, w.lat);
                if (bin != w.bin)
                    report_mismatch("bin", 64'(bin), 64'(w.bin));
                if (voluntary_count != w.cnt[0])
                    report_mismatch("voluntary_count", 64'(voluntary_count), 64'(w.cnt[0]));
                if (involuntary_count != w.cnt[1])
                    report_mismatch("involuntary_count", 64'(involuntary_count),
                                    64'(w.cnt[1]));
                if (bin_one_count != w.cnt[2])
                    report_mismatch("bin_one_count", 64'(bin_one_count), 64'(w.cnt[2]));
                if (bin_two_count != w.cnt[3])
                    report_mismatch("bin_two_count", 64'(bin_two_count), 64'(w.cnt[3]));
                if (bin_three_count != w.cnt[4])
                    report_mismatch("bin_three_count", 64'(bin_three_count), 64'(w.cnt[4]));
                if (bin_four_count != w.cnt[5])
                    report_mismatch("bin_four_count", 64'(bin_four_count), 64'(w.cnt[5]));
            end
        end
    end

    task automatic send_event(event_t e, logic typed, outcome_t typed_word);
        outcome_t w;
        // rotate the idling pattern every few dozen words
        case ((sent / 40) % 5)
            1:       begin send_idle_pct = 66; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 66; end
            3:       begin send_idle_pct = 36; recv_stall_pct = 36; end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid      = 1'b1;
        command       = e.cmd;
        now_ns        = e.now;
        task_pid      = e.pid;
        task_key      = e.grp;
        task_group_ok = e.gok;
        prior_pid     = e.ppid;
        prev_running  = e.prun;
        prev_group    = e.pgrp;
        prev_group_ok = e.pok;
        do
            @(posedge clk);
        while (!in_ready);
        w = histogram_step(e);
        expected_words.push_back(typed ? typed_word : w);
        sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic send_plain(event_t e);
        send_event(e, 1'b0, '0);
    endtask

    task automatic wait_idle();
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_bounds(logic [31:0] a, logic [31:0] b, logic [31:0] c);
        wait_idle();
        cfg_we = 1'b1;
        cfg_index = CFG_FIRST;  cfg_data = a; @(negedge clk);
        cfg_index = CFG_SECOND; cfg_data = b; @(negedge clk);
        cfg_index = CFG_THIRD;  cfg_data = c; @(negedge clk);
        cfg_we = 1'b0;
        bound_a = a;
        bound_b = b;
        bound_c = c;
    endtask

    function automatic logic [21:0] pick_pid();
        case ($urandom_range(9))
            0:       return 22'h3FFFFF;
            1:       return 22'h2AAAAA;
            2:       return 22'h155555;
            3:       return 22'd0;
            4:       return 22'($urandom);
            default: return 22'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic [63:0] pick_key();
        case ($urandom_range(9))
            0:       return 64'd0;
            1:       return '1;
            2:       return 64'hAAAA_AAAA_AAAA_AAAA;
            3:       return 64'h5555_5555_5555_5555;
            4:       return {$urandom, $urandom};
            default: return 64'($urandom_range(1, 4));
        endcase
    endfunction

    function automatic logic [63:0] next_time();
        case ($urandom_range(19))
            0:       clock_ns = {$urandom, $urandom};
            1:       clock_ns = 64'd0;
            default: clock_ns = clock_ns + 64'($urandom_range(0, 60000000));
        endcase
        return clock_ns;
    endfunction

    task automatic random_mix(int n);
        int pick;
        logic [2:0] c;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 30)      c = CMD_WAKEUP;
            else if (pick < 65) c = CMD_SWITCH;
            else if (pick < 73) c = CMD_EXIT;
            else if (pick < 78) c = CMD_REMOVE;
            else if (pick < 86) c = CMD_READ_GROUP;
            else if (pick < 92) c = CMD_READ_GLOBAL;
            else if (pick < 96) c = CMD_NONE;
            else                c = CMD_SPARE;
            send_plain(mk(c, next_time(), pick_pid(), pick_key(), 1'($urandom),
                          pick_pid(), 1'($urandom), pick_key(), 1'($urandom)));
        end
    endtask

    initial
    begin
        outcome_t tw;
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = CMD_WAKEUP;
        now_ns = '0; task_pid = '0; task_key = '0; task_group_ok = 1'b0;
        prior_pid = '0; prev_running = 1'b0; prev_group = '0; prev_group_ok = 1'b0;
        cfg_we = 1'b0; cfg_index = CFG_FIRST; cfg_data = '0;
        mismatches = 0; sent = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        clock_ns = 64'd1000;
        bound_a = FIRST_BOUND_RST;
        bound_b = SECOND_BOUND_RST;
        bound_c = THIRD_BOUND_RST;
        for (int i = 0; i < PEND_DEPTH; i++) pend_vld[i] = 1'b0;
        for (int i = 0; i < GRP_DEPTH; i++) grp_vld[i] = 1'b0;
        glob_cnt = '0;

        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        dir_rows.push_back('{mk(CMD_READ_GLOBAL, 0, 0, 0, 0, 0, 0, 0, 0), 1, STS_OK, 0, 0});
        dir_rows.push_back('{mk(CMD_READ_GROUP, 0, 0, 5, 1, 0, 0, 0, 0), 1, STS_NOT_FOUND, 0, 0});
        dir_rows.push_back('{mk(CMD_REMOVE, 0, 0, 5, 0, 0, 0, 0, 0), 1, STS_NOT_FOUND, 0, 0});
        dir_rows.push_back('{mk(CMD_WAKEUP, 50, 0, 0, 0, 0, 0, 0, 0), 1, STS_OK, 0, 0});
        dir_rows.push_back('{mk(CMD_SWITCH, 60, 0, 0, 0, 0, 0, 0, 0), 1, STS_NO_LAT, 0, 0});
        dir_rows.push_back('{mk(CMD_WAKEUP, 1000, 22'h3FFFFF, 0, 0, 0, 0, 0, 0),
                             1, STS_OK, 0, 0});
        // below the first bound, both groups counted
        dir_rows.push_back('{mk(CMD_SWITCH, 5001000, 22'h3FFFFF, 1, 1, 7, 0, 1, 1),
                             1, STS_OK, 5000000, 0});
        // a stamp of time zero counts as no stamp
        dir_rows.push_back('{mk(CMD_WAKEUP, 0, 1, 0, 0, 0, 0, 0, 0), 1, STS_OK, 0, 0});
        dir_rows.push_back('{mk(CMD_SWITCH, 100, 1, 1, 1, 0, 0, 0, 0), 1, STS_NO_LAT, 0, 0});
        // overwrite of a stamp, then a wrapped clock
        dir_rows.push_back('{mk(CMD_WAKEUP, 64'hFFFF_FFFF_FFFF_FFF0, 2, 0, 0, 0, 0, 0, 0),
                             1, STS_OK, 0, 0});
        dir_rows.push_back('{mk(CMD_WAKEUP, 64'hFFFF_FFFF_FFFF_FFF8, 2, 0, 0, 0, 0, 0, 0),
                             1, STS_OK, 0, 0});
        dir_rows.push_back('{mk(CMD_SWITCH, 8, 2, 0, 0, 3, 1, '1, 1), 1, STS_OK, 16, 0});
        // exactly on the second bound lands in the third range
        dir_rows.push_back('{mk(CMD_SWITCH, 20000008, 3, 1, 1, 0, 0, 0, 0),
                             1, STS_OK, 20000000, 2});
        dir_rows.push_back('{mk(CMD_WAKEUP, 100, 4, 0, 0, 0, 0, 0, 0), 1, STS_OK, 0, 0});
        dir_rows.push_back('{mk(CMD_EXIT, 150, 4, 0, 0, 0, 0, 0, 0), 1, STS_OK, 0, 0});
        dir_rows.push_back('{mk(CMD_SWITCH, 200, 4, 0, 0, 0, 0, 0, 0), 1, STS_NO_LAT, 0, 0});
        dir_rows.push_back('{mk(CMD_WAKEUP, 1, 5, 0, 0, 0, 0, 0, 0), 1, STS_OK, 0, 0});
        dir_rows.push_back('{mk(CMD_SWITCH, 50000001, 5, '1, 1, 0, 0, 0, 0),
                             1, STS_OK, 50000000, 3});
        dir_rows.push_back('{mk(CMD_WAKEUP, 1, 6, 0, 0, 0, 0, 0, 0), 1, STS_OK, 0, 0});
        dir_rows.push_back('{mk(CMD_SWITCH, 10000001, 6, 1, 1, 0, 0, 0, 0),
                             1, STS_OK, 10000000, 1});
        dir_rows.push_back('{mk(CMD_READ_GROUP, 0, 0, 1, 0, 0, 0, 0, 0), 0, STS_OK, 0, 0});
        dir_rows.push_back('{mk(CMD_READ_GROUP, 0, 0, '1, 0, 0, 0, 0, 0), 0, STS_OK, 0, 0});
        dir_rows.push_back('{mk(CMD_READ_GLOBAL, 0, 0, 0, 0, 0, 0, 0, 0), 0, STS_OK, 0, 0});
        dir_rows.push_back('{mk(CMD_NONE, '1, '1, '1, 1, '1, 1, '1, 1), 1, STS_OK, 0, 0});
        dir_rows.push_back('{mk(CMD_SPARE, 0, 9, 9, 1, 9, 1, 9, 1), 1, STS_OK, 0, 0});
        dir_rows.push_back('{mk(CMD_REMOVE, 0, 0, 1, 0, 0, 0, 0, 0), 1, STS_OK, 0, 0});
        dir_rows.push_back('{mk(CMD_READ_GROUP, 0, 0, 1, 1, 0, 0, 0, 0),
                             1, STS_NOT_FOUND, 0, 0});

        while (!in_ready)
            @(negedge clk);
        @(negedge clk);
        foreach (dir_rows[i])
        begin
            tw = '0;
            tw.st = dir_rows[i].st;
            tw.lat = dir_rows[i].lat;
            tw.bin = dir_rows[i].bin;
            send_event(dir_rows[i].ev, dir_rows[i].typed, tw);
        end

        random_mix(40);
        set_bounds(32'd0, 32'd0, 32'd0);
        random_mix(30);
        set_bounds('1, '1, '1);
        random_mix(30);
        set_bounds($urandom_range(0, 20000000), $urandom_range(10000000, 40000000),
                   $urandom_range(30000000, 60000000));
        random_mix(30);
        set_bounds($urandom, $urandom, $urandom);
        random_mix(20);
        set_bounds(FIRST_BOUND_RST, SECOND_BOUND_RST, THIRD_BOUND_RST);

        // fill the pending table past its depth, then take some of it back
        for (int i = 0; i < PEND_DEPTH + 6; i++)
            send_plain(mk(CMD_WAKEUP, next_time(), 22'(1000 + i), 0, 0, 0, 0, 0, 0));
        for (int i = 0; i < 20; i++)
            send_plain(mk(CMD_SWITCH, next_time(), 22'(1000 + PEND_DEPTH + 5 - 2 * i),
                          pick_key(), 1'($urandom), pick_pid(), 1'($urandom),
                          pick_key(), 1'($urandom)));

        // fill the group table until allocation fails
        for (int i = 0; i < GRP_DEPTH + 4; i++)
            send_plain(mk(CMD_SWITCH, next_time(), 0, 0, 0, 22'd9, 1'($urandom),
                          64'h1000_0000 + i, 1));
        send_plain(mk(CMD_WAKEUP, next_time(), 22'd77, 0, 0, 0, 0, 0, 0));
        send_plain(mk(CMD_SWITCH, next_time(), 22'd77, 64'hDEAD_0000, 1, 0, 0, 0, 0));
        send_plain(mk(CMD_READ_GROUP, 0, 0, 64'h1000_0000, 0, 0, 0, 0, 0));
        send_plain(mk(CMD_READ_GLOBAL, 0, 0, 0, 0, 0, 0, 0, 0));
        random_mix(40);

        wait_idle();
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* run_queue_latency_binner.f */
src/rqlb_pkg.sv
src/rqlb_front.sv
src/rqlb_back.sv
src/run_queue_latency_binner.sv
src/rqlb_checker.sv
test/run_queue_latency_binner_tb.sv
